/* rtl/hpg_pkg.sv */
// Package for the helix path generator.
// Shared constants, register index codes, arctangent table and saturation helpers.
package hpg_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int DIV_STEPS    = 64;
	localparam int STEP_W       = 5;
	localparam int CFG_W        = 26;

	localparam logic [25:0]        MIN_CYCLE = 26'd6554;
	localparam logic signed [33:0] GAIN_Q30  = 34'sd652032874;

	localparam int MODE_PINGPONG = 0;
	localparam int MODE_CW       = 1;
	localparam int MODE_FACING   = 2;

	typedef logic signed [33:0] cord_t;

	typedef enum logic [2:0] {
		REG_START_RADIUS,
		REG_END_RADIUS,
		REG_START_HEIGHT,
		REG_END_HEIGHT,
		REG_LAP_COUNT,
		REG_CYCLE_LENGTH,
		REG_PHASE_OFFSET,
		REG_MODE_BITS
	} cfg_idx_t;

	// atan(2^-i) in turns, Q0.32, truncated
	function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
		logic [31:0] a;
		unique case (i)
			5'd0:  a = 32'd536870912;
			5'd1:  a = 32'd316933405;
			5'd2:  a = 32'd167458907;
			5'd3:  a = 32'd85004756;
			5'd4:  a = 32'd42667331;
			5'd5:  a = 32'd21354465;
			5'd6:  a = 32'd10679838;
			5'd7:  a = 32'd5340245;
			5'd8:  a = 32'd2670163;
			5'd9:  a = 32'd1335086;
			5'd10: a = 32'd667544;
			5'd11: a = 32'd333772;
			5'd12: a = 32'd166886;
			5'd13: a = 32'd83443;
			5'd14: a = 32'd41721;
			5'd15: a = 32'd20860;
			5'd16: a = 32'd10430;
			5'd17: a = 32'd5215;
			5'd18: a = 32'd2607;
			5'd19: a = 32'd1303;
			5'd20: a = 32'd651;
			5'd21: a = 32'd325;
			5'd22: a = 32'd162;
			5'd23: a = 32'd81;
			default: a = 32'd0;
		endcase
		return a;
	endfunction

	function automatic logic signed [25:0] sat26(input logic signed [31:0] v);
		logic signed [25:0] r;
		if (v > 32'sd33554431)
			r = 26'sd33554431;
		else if (v < -32'sd33554432)
			r = -26'sd33554432;
		else
			r = v[25:0];
		return r;
	endfunction

	function automatic logic signed [15:0] sat16q(input logic signed [18:0] v);
		logic signed [15:0] r;
		if (v > 19'sd32767)
			r = 16'sd32767;
		else if (v < -19'sd32767)
			r = -16'sd32767;
		else
			r = v[15:0];
		return r;
	endfunction

endpackage

/* rtl/hpg_in_if.sv */
// Input channel of the helix path generator: valid/ready plus time stamp.
// Depends on nothing.
interface hpg_in_if;
	logic        valid;
	logic        ready;
	logic [47:0] time_now;

	modport source (output valid, output time_now, input ready);
	modport sink   (input valid, input time_now, output ready);
endinterface

/* rtl/hpg_out_if.sv */
// Output channel of the helix path generator: valid/ready plus position and rotation.
// Depends on nothing.
interface hpg_out_if;
	logic               valid;
	logic               ready;
	logic signed [25:0] pos_x;
	logic signed [25:0] pos_y;
	logic signed [25:0] pos_z;
	logic signed [15:0] rot_w;
	logic signed [15:0] rot_y;
	logic               rot_valid;

	modport source (output valid, output pos_x, output pos_y, output pos_z,
		output rot_w, output rot_y, output rot_valid, input ready);
	modport sink   (input valid, input pos_x, input pos_y, input pos_z,
		input rot_w, input rot_y, input rot_valid, output ready);
endinterface

/* rtl/hpg_div_cell.sv */
// One restoring-division cell: shifts in a dividend bit, subtracts the divisor if it fits.
// Depends on hpg_pkg.
module hpg_div_cell import hpg_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [25:0] divisor,
	input  logic [25:0] rem_i,
	input  logic [63:0] dvd_i,
	input  logic [15:0] quo_i,
	output logic [25:0] rem_o,
	output logic [63:0] dvd_o,
	output logic [15:0] quo_o
);

	logic [26:0] trial;
	logic [26:0] diff;
	logic        fits;

	always_comb begin
		trial = {rem_i, dvd_i[63]};
		fits  = trial >= {1'b0, divisor};
		diff  = trial - {1'b0, divisor};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= fits ? diff[25:0] : trial[25:0];
			dvd_o <= {dvd_i[62:0], 1'b0};
			quo_o <= {quo_i[14:0], fits};
		end
	end

endmodule

/* rtl/hpg_cordic_cell.sv */
// One rotation-mode CORDIC micro-rotation; the step index selects shift and arctangent.
// Depends on hpg_pkg.
module hpg_cordic_cell import hpg_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [STEP_W-1:0] step,
	input  cord_t             x_i,
	input  cord_t             y_i,
	input  cord_t             z_i,
	output cord_t             x_o,
	output cord_t             y_o,
	output cord_t             z_o
);

	cord_t dx;
	cord_t dy;
	cord_t a;

	always_comb begin
		dx = x_i >>> step;
		dy = y_i >>> step;
		a  = $signed({2'b00, atan_turn(step)});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_i[33]) begin
				x_o <= x_i - dy;
				y_o <= y_i + dx;
				z_o <= z_i - a;
			end else begin
				x_o <= x_i + dy;
				y_o <= y_i - dx;
				z_o <= z_i + a;
			end
		end
	end

endmodule

/* rtl/helix_path_generator.sv */
// Helix path generator top level: config registers, phase divider chain, blends, CORDIC chains.
// Depends on hpg_pkg, hpg_in_if, hpg_out_if, hpg_div_cell, hpg_cordic_cell.
//
//  port       dir   kind         payload
//  din        in    valid/ready  time_now
//  dout       out   valid/ready  pos_x pos_y pos_z rot_w rot_y rot_valid
//  cfg_*      in    write only   cfg_index, cfg_wdata
//
// One transaction per cycle while dout is not stalled; pipeline of 64 divider cells, 3 blend stages,
// 16 CORDIC cells and 2 output stages. The divider chain sets the depth.
// Reset clears the valid pipeline and loads the register defaults.
// A stall at dout with a full output register freezes the whole pipeline.
module helix_path_generator import hpg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wen,
	input  logic [2:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	hpg_in_if.sink           din,
	hpg_out_if.source        dout
);

	localparam int S1  = DIV_STEPS;
	localparam int S3  = DIV_STEPS + 2;
	localparam int LAT = DIV_STEPS + 3 + CORDIC_STEPS + 2;

	logic [24:0] start_radius_q, end_radius_q;
	logic [25:0] start_height_q, end_height_q;
	logic [22:0] lap_count_q;
	logic [25:0] cycle_length_q;
	logic [15:0] phase_offset_q;
	logic [2:0]  mode_bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_radius_q <= 25'd19661;
			end_radius_q   <= 25'd163840;
			start_height_q <= 26'd0;
			end_height_q   <= 26'd393216;
			lap_count_q    <= 23'd196608;
			cycle_length_q <= 26'd786432;
			phase_offset_q <= 16'd0;
			mode_bits_q    <= 3'd1;
		end else if (cfg_wen) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_START_RADIUS: start_radius_q <= cfg_wdata[24:0];
				REG_END_RADIUS:   end_radius_q   <= cfg_wdata[24:0];
				REG_START_HEIGHT: start_height_q <= cfg_wdata[25:0];
				REG_END_HEIGHT:   end_height_q   <= cfg_wdata[25:0];
				REG_LAP_COUNT:    lap_count_q    <= cfg_wdata[22:0];
				REG_CYCLE_LENGTH: cycle_length_q <= cfg_wdata[25:0];
				REG_PHASE_OFFSET: phase_offset_q <= cfg_wdata[15:0];
				REG_MODE_BITS:    mode_bits_q    <= cfg_wdata[2:0];
			endcase
		end
	end

	logic           adv;
	logic [LAT-1:0] vld_q;

	assign adv        = !vld_q[LAT-1] || dout.ready;
	assign din.ready  = adv;
	assign dout.valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (adv)
			vld_q <= {vld_q[LAT-2:0], din.valid};
	end

	// phase divider chain: low 16 quotient bits of time*2^16/period
	logic [25:0] period;
	logic [25:0] drem [DIV_STEPS+1];
	logic [63:0] ddvd [DIV_STEPS+1];
	logic [15:0] dquo [DIV_STEPS+1];

	assign period  = (cycle_length_q < MIN_CYCLE) ? MIN_CYCLE : cycle_length_q;
	assign drem[0] = '0;
	assign ddvd[0] = {din.time_now, 16'd0};
	assign dquo[0] = '0;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		hpg_div_cell u_cell (
			.clk     (clk),
			.en      (adv),
			.divisor (period),
			.rem_i   (drem[k]),
			.dvd_i   (ddvd[k]),
			.quo_i   (dquo[k]),
			.rem_o   (drem[k+1]),
			.dvd_o   (ddvd[k+1]),
			.quo_o   (dquo[k+1])
		);
	end

	// stage 1: phase and fold
	logic [15:0] ph;
	logic [16:0] u_s1;

	assign ph = dquo[DIV_STEPS] + phase_offset_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (!mode_bits_q[MODE_PINGPONG])
				u_s1 <= {1'b0, ph};
			else if (ph[15])
				u_s1 <= 17'(18'd131072 - {1'b0, ph, 1'b0});
			else
				u_s1 <= {ph, 1'b0};
		end
	end

	// stage 2: blend and angle products
	logic signed [26:0] dr, dh;
	logic signed [44:0] drp_s2, dhp_s2;
	logic [39:0]        turns_s2;

	assign dr = $signed({2'b00, end_radius_q}) - $signed({2'b00, start_radius_q});
	assign dh = $signed({end_height_q[25], end_height_q})
		- $signed({start_height_q[25], start_height_q});

	always_ff @(posedge clk) begin
		if (adv) begin
			drp_s2   <= dr * $signed({1'b0, u_s1});
			dhp_s2   <= dh * $signed({1'b0, u_s1});
			turns_s2 <= {17'd0, lap_count_q} * {23'd0, u_s1};
		end
	end

	// stage 3: finish blends, quadrant reduction
	logic signed [28:0] rsh, hsh;
	logic signed [29:0] rfull, hfull;
	logic [31:0]        ang, half, ta, th;
	logic               fa, fh;
	logic signed [26:0] r_s3;
	logic signed [25:0] h_s3;
	cord_t              za_s3, zh_s3;
	logic               fa_s3, fh_s3;

	always_comb begin
		rsh   = 29'((drp_s2 + 45'sd32768) >>> 16);
		hsh   = 29'((dhp_s2 + 45'sd32768) >>> 16);
		rfull = $signed({5'd0, start_radius_q}) + 30'(rsh);
		hfull = 30'($signed(start_height_q)) + 30'(hsh);
		ang   = turns_s2[31:0];
		half  = turns_s2[32:1];
		if (mode_bits_q[MODE_CW]) begin
			ang  = 32'd0 - ang;
			half = 32'd0 - half;
		end
		ta = ang + 32'h4000_0000;
		th = half + 32'h4000_0000;
		fa = ta[31];
		fh = th[31];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s3  <= rfull[29] ? 27'sd0 : rfull[26:0];
			h_s3  <= sat26(32'(hfull));
			fa_s3 <= fa;
			fh_s3 <= fh;
			za_s3 <= 34'($signed(fa ? (ang ^ 32'h8000_0000) : ang));
			zh_s3 <= 34'($signed(fh ? (half ^ 32'h8000_0000) : half));
		end
	end

	// CORDIC chains for the angle and the half angle
	cord_t cxa [CORDIC_STEPS+1], cya [CORDIC_STEPS+1], cza [CORDIC_STEPS+1];
	cord_t cxh [CORDIC_STEPS+1], cyh [CORDIC_STEPS+1], czh [CORDIC_STEPS+1];
	logic signed [26:0] r_d  [CORDIC_STEPS];
	logic signed [25:0] h_d  [CORDIC_STEPS];
	logic               fa_d [CORDIC_STEPS];
	logic               fh_d [CORDIC_STEPS];

	assign cxa[0] = GAIN_Q30;
	assign cya[0] = '0;
	assign cza[0] = za_s3;
	assign cxh[0] = GAIN_Q30;
	assign cyh[0] = '0;
	assign czh[0] = zh_s3;

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
		hpg_cordic_cell u_ang (
			.clk  (clk),
			.en   (adv),
			.step (STEP_W'(k)),
			.x_i  (cxa[k]),
			.y_i  (cya[k]),
			.z_i  (cza[k]),
			.x_o  (cxa[k+1]),
			.y_o  (cya[k+1]),
			.z_o  (cza[k+1])
		);
		hpg_cordic_cell u_half (
			.clk  (clk),
			.en   (adv),
			.step (STEP_W'(k)),
			.x_i  (cxh[k]),
			.y_i  (cyh[k]),
			.z_i  (czh[k]),
			.x_o  (cxh[k+1]),
			.y_o  (cyh[k+1]),
			.z_o  (czh[k+1])
		);
		if (k == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (adv) begin
					r_d[k]  <= r_s3;
					h_d[k]  <= h_s3;
					fa_d[k] <= fa_s3;
					fh_d[k] <= fh_s3;
				end
			end
		end else begin : g_tail
			always_ff @(posedge clk) begin
				if (adv) begin
					r_d[k]  <= r_d[k-1];
					h_d[k]  <= h_d[k-1];
					fa_d[k] <= fa_d[k-1];
					fh_d[k] <= fh_d[k-1];
				end
			end
		end
	end

	// stage 4: unfold, scale by radius, quaternion rounding
	cord_t              ca, sa, ch, sh;
	logic signed [18:0] qw, qy;
	logic signed [60:0] mx_s4, mz_s4;
	logic signed [25:0] h_s4;
	logic signed [15:0] rw_s4, ry_s4;

	always_comb begin
		ca = fa_d[CORDIC_STEPS-1] ? -cxa[CORDIC_STEPS] : cxa[CORDIC_STEPS];
		sa = fa_d[CORDIC_STEPS-1] ? -cya[CORDIC_STEPS] : cya[CORDIC_STEPS];
		ch = fh_d[CORDIC_STEPS-1] ? -cxh[CORDIC_STEPS] : cxh[CORDIC_STEPS];
		sh = fh_d[CORDIC_STEPS-1] ? -cyh[CORDIC_STEPS] : cyh[CORDIC_STEPS];
		qw = 19'((ch + 34'sd16384) >>> 15);
		qy = 19'((sh + 34'sd16384) >>> 15);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s4 <= ca * r_d[CORDIC_STEPS-1];
			mz_s4 <= sa * r_d[CORDIC_STEPS-1];
			h_s4  <= h_d[CORDIC_STEPS-1];
			rw_s4 <= sat16q(qw);
			ry_s4 <= sat16q(qy);
		end
	end

	// stage 5: output register
	logic signed [31:0] xr, zr;

	assign xr = 32'((mx_s4 + 61'sd536870912) >>> 30);
	assign zr = 32'sd0 - 32'((mz_s4 + 61'sd536870912) >>> 30);

	always_ff @(posedge clk) begin
		if (adv) begin
			dout.pos_x     <= sat26(xr);
			dout.pos_y     <= h_s4;
			dout.pos_z     <= sat26(zr);
			dout.rot_w     <= mode_bits_q[MODE_FACING] ? rw_s4 : 16'sd0;
			dout.rot_y     <= mode_bits_q[MODE_FACING] ? ry_s4 : 16'sd0;
			dout.rot_valid <= mode_bits_q[MODE_FACING];
		end
	end

`ifndef SYNTHESIS
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("pipeline moved during stall");
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!din.ready |-> dout.valid)
		else $error("input blocked with empty output");
	a_facing_off: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && !mode_bits_q[MODE_FACING] |->
			dout.rot_w == 16'sd0 && dout.rot_y == 16'sd0 && !dout.rot_valid)
		else $error("rotation present with facing off");
	a_clamp_radius: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[S3] |-> !r_s3[26])
		else $error("negative radius");
	a_s1_fold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[S1] && mode_bits_q[MODE_PINGPONG] |-> !u_s1[0])
		else $error("ping-pong phase odd");
`endif

endmodule
